### hdl/spring_damper_force_defines.svh
// assertion macros for the spring damper force block
`ifndef SPRING_DAMPER_FORCE_DEFINES_SVH
`define SPRING_DAMPER_FORCE_DEFINES_SVH

// same-cycle implication
`define SPDF_AST_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
    else $error(msg);

// next-cycle implication
`define SPDF_AST_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> cons) \
    else $error(msg);

`endif

### hdl/spdf_pkg.sv
`timescale 1ns / 1ps
package spdf_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int POS_W  = 32;
  localparam int PAR_W  = 31;
  localparam int DIF_W  = POS_W + 1;
  localparam int SQ_W   = 2 * DIF_W;
  localparam int RAD_W  = SQ_W + 2;
  localparam int LEN_W  = RAD_W / 2;
  localparam int TERM_W = 63;
  localparam int LAT_BASE = LEN_W + 11;

  localparam logic [63:0] CAP62 = 64'd1 << 62;
  localparam logic [63:0] CAP31 = 64'd1 << 31;

  typedef struct packed {
    logic signed [POS_W-1:0] anchor_x;
    logic signed [POS_W-1:0] anchor_y;
    logic signed [POS_W-1:0] body_x;
    logic signed [POS_W-1:0] body_y;
    logic signed [POS_W-1:0] vel_x;
    logic signed [POS_W-1:0] vel_y;
    logic [PAR_W-1:0]        rest_length;
    logic [PAR_W-1:0]        stiffness;
    logic [PAR_W-1:0]        damping;
  } request_t;

  typedef struct packed {
    logic signed [POS_W-1:0] force_x;
    logic signed [POS_W-1:0] force_y;
    logic                    applied;
  } result_t;

  typedef struct packed {
    logic [DIF_W-1:0] mx;
    logic [DIF_W-1:0] my;
  } geo_t;

  typedef struct packed {
    logic                    neg_x;
    logic                    neg_y;
    logic signed [POS_W-1:0] vel_x;
    logic signed [POS_W-1:0] vel_y;
    logic [PAR_W-1:0]        rest_length;
    logic [PAR_W-1:0]        stiffness;
    logic [PAR_W-1:0]        damping;
  } kin_t;

endpackage

### hdl/spring_damper_force.sv
`timescale 1ns / 1ps
// Spring damper force, 2D, fixed point with FRAC_BITS fraction bits.
// Request channel: drive request and raise start; the request is taken at
// each rising edge with start high and busy low. busy is always low, so a
// new request may be given in every cycle and requests overlap in flight.
// Result channel: done is high for exactly one cycle with the force on the
// second body and the applied flag on result; results come out in request
// order and the receiver must take them in that cycle.
// Pipeline: 3 front stages (input register, difference, squares), 34
// square root stages (one root bit each), FRAC_BITS + 1 divider stages
// (one unit-vector bit each; FRAC_BITS is 16 by default, Q16.16) and 7
// multiply and saturate stages.
// Throughput: one request per cycle, with no gaps.
// Reset: rst clears every stage valid bit; requests in flight are dropped
// and no done follows them. Coincident positions give zero force and
// applied low.
module spring_damper_force import spdf_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  request_t request,
  output logic     done,
  output result_t  result
);

  localparam int GEO_W  = $bits(geo_t);
  localparam int KIN_W  = $bits(kin_t);
  localparam int SIDE_W = GEO_W + KIN_W;

  logic     s0_vld;
  request_t s0_req;

  logic signed [DIF_W-1:0] dx_c, dy_c;

  logic             s1_vld;
  geo_t             s1_geo;
  kin_t             s1_kin;

  logic             s2_vld;
  logic [SQ_W-1:0]  s2_sqx, s2_sqy;
  kin_t             s2_kin;
  geo_t             s2_geo;

  logic [RAD_W-1:0]  rad_c;
  logic              sq_vld;
  logic [LEN_W-1:0]  sq_len;
  logic [SIDE_W-1:0] sq_side;
  geo_t              sq_geo;
  kin_t              sq_kin;

  logic               dv_vld;
  logic [FRAC_BITS:0] dv_qx, dv_qy;
  logic [LEN_W-1:0]   dv_len;
  logic [KIN_W-1:0]   dv_side;
  kin_t               dv_kin;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_vld <= 1'b0;
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
    end else begin
      s0_vld <= start && !busy;
      s1_vld <= s0_vld;
      s2_vld <= s1_vld;
    end
  end

  assign dx_c = DIF_W'(s0_req.anchor_x) - DIF_W'(s0_req.body_x);
  assign dy_c = DIF_W'(s0_req.anchor_y) - DIF_W'(s0_req.body_y);

  always_ff @(posedge clk) begin
    s0_req                <= request;
    s1_geo.mx             <= dx_c[DIF_W-1] ? DIF_W'(-dx_c) : DIF_W'(dx_c);
    s1_geo.my             <= dy_c[DIF_W-1] ? DIF_W'(-dy_c) : DIF_W'(dy_c);
    s1_kin.neg_x          <= dx_c[DIF_W-1];
    s1_kin.neg_y          <= dy_c[DIF_W-1];
    s1_kin.vel_x          <= s0_req.vel_x;
    s1_kin.vel_y          <= s0_req.vel_y;
    s1_kin.rest_length    <= s0_req.rest_length;
    s1_kin.stiffness      <= s0_req.stiffness;
    s1_kin.damping        <= s0_req.damping;
    s2_sqx                <= s1_geo.mx * s1_geo.mx;
    s2_sqy                <= s1_geo.my * s1_geo.my;
    s2_geo                <= s1_geo;
    s2_kin                <= s1_kin;
  end

  assign rad_c = RAD_W'(s2_sqx) + RAD_W'(s2_sqy);

  spdf_sqrt #(
    .SIDE_W (SIDE_W)
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s2_vld),
    .rad       (rad_c),
    .side_in   ({s2_geo, s2_kin}),
    .out_valid (sq_vld),
    .root      (sq_len),
    .side_out  (sq_side)
  );

  assign {sq_geo, sq_kin} = sq_side;

  spdf_div #(
    .FRAC_BITS (FRAC_BITS),
    .SIDE_W    (KIN_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sq_vld),
    .num_x     (sq_geo.mx),
    .num_y     (sq_geo.my),
    .den       (sq_len),
    .side_in   (sq_kin),
    .out_valid (dv_vld),
    .quo_x     (dv_qx),
    .quo_y     (dv_qy),
    .den_out   (dv_len),
    .side_out  (dv_side)
  );

  assign dv_kin = dv_side;

  spdf_force #(
    .FRAC_BITS (FRAC_BITS)
  ) u_force (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dv_vld),
    .len       (dv_len),
    .quo_x     (dv_qx),
    .quo_y     (dv_qy),
    .kin       (dv_kin),
    .out_valid (done),
    .res       (result)
  );

endmodule

### hdl/spdf_sqrt.sv
`timescale 1ns / 1ps
module spdf_sqrt import spdf_pkg::*; #(
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [RAD_W-1:0]  rad,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [LEN_W-1:0]  root,
  output logic [SIDE_W-1:0] side_out
);

  localparam int REM_W = LEN_W + 2;
  localparam int ACC_W = REM_W + 2;

  logic              vld [1:LEN_W];
  logic [REM_W-1:0]  rem [1:LEN_W-1];
  logic [RAD_W-1:0]  rd  [1:LEN_W-1];
  logic [LEN_W-1:0]  rt  [1:LEN_W];
  logic [SIDE_W-1:0] sd  [1:LEN_W];

  for (genvar i = 0; i < LEN_W; i++) begin : g_step
    logic              v_c;
    logic [REM_W-1:0]  rem_c;
    logic [RAD_W-1:0]  rd_c;
    logic [LEN_W-1:0]  rt_c;
    logic [SIDE_W-1:0] sd_c;
    logic [ACC_W-1:0]  acc;
    logic [ACC_W-1:0]  trial;
    logic              fit;

    if (i == 0) begin : g_src
      assign v_c   = in_valid;
      assign rem_c = '0;
      assign rd_c  = rad;
      assign rt_c  = '0;
      assign sd_c  = side_in;
    end else begin : g_src
      assign v_c   = vld[i];
      assign rem_c = rem[i];
      assign rd_c  = rd[i];
      assign rt_c  = rt[i];
      assign sd_c  = sd[i];
    end

    assign acc   = {rem_c, rd_c[RAD_W-1 -: 2]};
    assign trial = {2'b00, rt_c, 2'b01};
    assign fit   = acc >= trial;

    always_ff @(posedge clk) begin
      if (rst) vld[i+1] <= 1'b0;
      else vld[i+1] <= v_c;
    end

    always_ff @(posedge clk) begin
      rt[i+1] <= {rt_c[LEN_W-2:0], fit};
      sd[i+1] <= sd_c;
    end

    if (i < LEN_W - 1) begin : g_rem
      always_ff @(posedge clk) begin
        rem[i+1] <= fit ? REM_W'(acc - trial) : REM_W'(acc);
        rd[i+1]  <= {rd_c[RAD_W-3:0], 2'b00};
      end
    end
  end

  assign out_valid = vld[LEN_W];
  assign root      = rt[LEN_W];
  assign side_out  = sd[LEN_W];

endmodule

### hdl/spdf_div.sv
`timescale 1ns / 1ps
module spdf_div import spdf_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int SIDE_W    = 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [DIF_W-1:0]   num_x,
  input  logic [DIF_W-1:0]   num_y,
  input  logic [LEN_W-1:0]   den,
  input  logic [SIDE_W-1:0]  side_in,
  output logic               out_valid,
  output logic [FRAC_BITS:0] quo_x,
  output logic [FRAC_BITS:0] quo_y,
  output logic [LEN_W-1:0]   den_out,
  output logic [SIDE_W-1:0]  side_out
);

  localparam int NS  = FRAC_BITS + 1;
  localparam int T_W = LEN_W + 1;

  logic               vld [1:NS];
  logic [LEN_W-1:0]   rx  [1:NS-1];
  logic [LEN_W-1:0]   ry  [1:NS-1];
  logic [FRAC_BITS:0] qx  [1:NS];
  logic [FRAC_BITS:0] qy  [1:NS];
  logic [LEN_W-1:0]   dn  [1:NS];
  logic [SIDE_W-1:0]  sd  [1:NS];

  for (genvar i = 0; i < NS; i++) begin : g_step
    logic               v_c;
    logic [LEN_W-1:0]   rx_c;
    logic [LEN_W-1:0]   ry_c;
    logic [FRAC_BITS:0] qx_c;
    logic [FRAC_BITS:0] qy_c;
    logic [LEN_W-1:0]   dn_c;
    logic [SIDE_W-1:0]  sd_c;
    logic [T_W-1:0]     tx;
    logic [T_W-1:0]     ty;
    logic [T_W-1:0]     dd;
    logic               fx;
    logic               fy;

    if (i == 0) begin : g_src
      // integer quotient bit first, numerator never exceeds the length
      assign v_c  = in_valid;
      assign rx_c = LEN_W'(num_x);
      assign ry_c = LEN_W'(num_y);
      assign qx_c = '0;
      assign qy_c = '0;
      assign dn_c = den;
      assign sd_c = side_in;
      assign tx   = {1'b0, rx_c};
      assign ty   = {1'b0, ry_c};
    end else begin : g_src
      assign v_c  = vld[i];
      assign rx_c = rx[i];
      assign ry_c = ry[i];
      assign qx_c = qx[i];
      assign qy_c = qy[i];
      assign dn_c = dn[i];
      assign sd_c = sd[i];
      assign tx   = {rx_c, 1'b0};
      assign ty   = {ry_c, 1'b0};
    end

    assign dd = {1'b0, dn_c};
    assign fx = tx >= dd;
    assign fy = ty >= dd;

    always_ff @(posedge clk) begin
      if (rst) vld[i+1] <= 1'b0;
      else vld[i+1] <= v_c;
    end

    always_ff @(posedge clk) begin
      qx[i+1] <= {qx_c[FRAC_BITS-1:0], fx};
      qy[i+1] <= {qy_c[FRAC_BITS-1:0], fy};
      dn[i+1] <= dn_c;
      sd[i+1] <= sd_c;
    end

    if (i < NS - 1) begin : g_rem
      always_ff @(posedge clk) begin
        rx[i+1] <= fx ? LEN_W'(tx - dd) : LEN_W'(tx);
        ry[i+1] <= fy ? LEN_W'(ty - dd) : LEN_W'(ty);
      end
    end
  end

  assign out_valid = vld[NS];
  assign quo_x     = qx[NS];
  assign quo_y     = qy[NS];
  assign den_out   = dn[NS];
  assign side_out  = sd[NS];

endmodule

### hdl/spdf_force.sv
`timescale 1ns / 1ps
module spdf_force import spdf_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [LEN_W-1:0]   len,
  input  logic [FRAC_BITS:0] quo_x,
  input  logic [FRAC_BITS:0] quo_y,
  input  kin_t               kin,
  output logic               out_valid,
  output result_t            res
);

  localparam int Q_W    = FRAC_BITS + 1;
  localparam int N_W    = FRAC_BITS + 2;
  localparam int PV_W   = POS_W + N_W;
  localparam int SUM_W  = PV_W + 1;
  localparam int DOT_W  = SUM_W - FRAC_BITS;
  localparam int X_W    = LEN_W + 1;
  localparam int KX_W   = PAR_W + LEN_W;
  localparam int CD_W   = PAR_W + DOT_W;
  localparam int TOT_W  = TERM_W + 1;
  localparam int HALF_W = TOT_W / 2;
  localparam int PP_W   = HALF_W + Q_W;
  localparam int FULL_W = TOT_W + Q_W;
  localparam logic [POS_W-1:0] SMAX = {1'b0, {(POS_W-1){1'b1}}};

  function automatic logic [POS_W-1:0] sat_force(input logic [POS_W-1:0] m,
                                                 input logic neg, input logic app);
    logic [POS_W-1:0] r;
    r = '0;
    if (app && m != '0) begin
      if (neg) r = -m;
      else if (m > SMAX) r = SMAX;
      else r = m;
    end
    return r;
  endfunction

  // stage a: unit vector, velocity products, spring stretch product
  logic [N_W-1:0]          ux, uy;
  logic signed [N_W-1:0]   nx, ny;
  logic signed [PV_W-1:0]  px_c, py_c;
  logic signed [X_W-1:0]   x_c;
  logic [LEN_W-1:0]        xm_c;

  assign ux   = {1'b0, quo_x};
  assign uy   = {1'b0, quo_y};
  assign nx   = kin.neg_x ? -ux : ux;
  assign ny   = kin.neg_y ? -uy : uy;
  assign px_c = kin.vel_x * nx;
  assign py_c = kin.vel_y * ny;
  assign x_c  = $signed({1'b0, len}) - $signed(X_W'(kin.rest_length));
  assign xm_c = x_c[X_W-1] ? LEN_W'(-x_c) : LEN_W'(x_c);

  logic                   a_vld, a_xneg, a_nxneg, a_nyneg, a_app;
  logic signed [PV_W-1:0] a_px, a_py;
  logic [KX_W-1:0]        a_kx;
  logic [Q_W-1:0]         a_qx, a_qy;
  logic [PAR_W-1:0]       a_damp;

  always_ff @(posedge clk) begin
    a_px    <= px_c;
    a_py    <= py_c;
    a_kx    <= kin.stiffness * xm_c;
    a_xneg  <= x_c[X_W-1];
    a_qx    <= quo_x;
    a_qy    <= quo_y;
    a_nxneg <= kin.neg_x && quo_x != '0;
    a_nyneg <= kin.neg_y && quo_y != '0;
    a_damp  <= kin.damping;
    a_app   <= len != '0;
  end

  // stage b: dot product, spring term limit
  logic signed [SUM_W-1:0] sum_c;
  logic [SUM_W-1:0]        smag;
  logic [KX_W-1:0]         kq;

  assign sum_c = a_px + a_py;
  assign smag  = sum_c[SUM_W-1] ? -sum_c : sum_c;
  assign kq    = a_kx >> FRAC_BITS;

  logic                b_vld, b_dneg, b_xneg, b_nxneg, b_nyneg, b_app;
  logic [DOT_W-1:0]    b_dotm;
  logic [TERM_W-1:0]   b_sprm;
  logic [Q_W-1:0]      b_qx, b_qy;
  logic [PAR_W-1:0]    b_damp;

  always_ff @(posedge clk) begin
    b_dotm  <= DOT_W'(smag >> FRAC_BITS);
    b_dneg  <= sum_c[SUM_W-1];
    b_sprm  <= (kq > KX_W'(CAP62)) ? TERM_W'(CAP62) : TERM_W'(kq);
    b_xneg  <= a_xneg;
    b_qx    <= a_qx;
    b_qy    <= a_qy;
    b_nxneg <= a_nxneg;
    b_nyneg <= a_nyneg;
    b_damp  <= a_damp;
    b_app   <= a_app;
  end

  // stage c: damper product, signed spring term
  logic               c_vld, c_dneg, c_nxneg, c_nyneg, c_app;
  logic [CD_W-1:0]    c_cd;
  logic [TOT_W-1:0]   c_spr;
  logic [Q_W-1:0]     c_qx, c_qy;

  always_ff @(posedge clk) begin
    c_cd    <= b_damp * b_dotm;
    c_spr   <= b_xneg ? TOT_W'({1'b0, b_sprm}) : -TOT_W'({1'b0, b_sprm});
    c_dneg  <= b_dneg;
    c_qx    <= b_qx;
    c_qy    <= b_qy;
    c_nxneg <= b_nxneg;
    c_nyneg <= b_nyneg;
    c_app   <= b_app;
  end

  // stage d: total term, wraps like a 64-bit signed sum
  logic [CD_W-1:0]   cq;
  logic [TERM_W-1:0] dmpm;
  logic [TOT_W-1:0]  dmp_c, tot_c;

  assign cq    = c_cd >> FRAC_BITS;
  assign dmpm  = (cq > CD_W'(CAP62)) ? TERM_W'(CAP62) : TERM_W'(cq);
  assign dmp_c = c_dneg ? -TOT_W'(dmpm) : TOT_W'(dmpm);
  assign tot_c = c_spr + dmp_c;

  logic               d_vld, d_tneg, d_nxneg, d_nyneg, d_app;
  logic [TOT_W-1:0]   d_tmag;
  logic [Q_W-1:0]     d_qx, d_qy;

  always_ff @(posedge clk) begin
    d_tmag  <= tot_c[TOT_W-1] ? -tot_c : tot_c;
    d_tneg  <= tot_c[TOT_W-1];
    d_qx    <= c_qx;
    d_qy    <= c_qy;
    d_nxneg <= c_nxneg;
    d_nyneg <= c_nyneg;
    d_app   <= c_app;
  end

  // stage e: partial products of total times unit vector
  logic               e_vld, e_fnegx, e_fnegy, e_app;
  logic [PP_W-1:0]    e_lox, e_hix, e_loy, e_hiy;

  always_ff @(posedge clk) begin
    e_lox   <= d_tmag[HALF_W-1:0] * d_qx;
    e_hix   <= d_tmag[TOT_W-1:HALF_W] * d_qx;
    e_loy   <= d_tmag[HALF_W-1:0] * d_qy;
    e_hiy   <= d_tmag[TOT_W-1:HALF_W] * d_qy;
    e_fnegx <= d_tneg == d_nxneg;
    e_fnegy <= d_tneg == d_nyneg;
    e_app   <= d_app;
  end

  // stage f: combine, scale, limit magnitude
  logic [FULL_W-1:0] fullx, fully, mqx, mqy;

  assign fullx = (FULL_W'(e_hix) << HALF_W) + FULL_W'(e_lox);
  assign fully = (FULL_W'(e_hiy) << HALF_W) + FULL_W'(e_loy);
  assign mqx   = fullx >> FRAC_BITS;
  assign mqy   = fully >> FRAC_BITS;

  logic             f_vld, f_fnegx, f_fnegy, f_app;
  logic [POS_W-1:0] f_mx, f_my;

  always_ff @(posedge clk) begin
    f_mx    <= (mqx > FULL_W'(CAP31)) ? POS_W'(CAP31) : POS_W'(mqx);
    f_my    <= (mqy > FULL_W'(CAP31)) ? POS_W'(CAP31) : POS_W'(mqy);
    f_fnegx <= e_fnegx;
    f_fnegy <= e_fnegy;
    f_app   <= e_app;
  end

  // stage g: sign and 32-bit saturation into the result register
  always_ff @(posedge clk) begin
    res.force_x <= sat_force(f_mx, f_fnegx, f_app);
    res.force_y <= sat_force(f_my, f_fnegy, f_app);
    res.applied <= f_app;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld     <= 1'b0;
      b_vld     <= 1'b0;
      c_vld     <= 1'b0;
      d_vld     <= 1'b0;
      e_vld     <= 1'b0;
      f_vld     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      a_vld     <= in_valid;
      b_vld     <= a_vld;
      c_vld     <= b_vld;
      d_vld     <= c_vld;
      e_vld     <= d_vld;
      f_vld     <= e_vld;
      out_valid <= f_vld;
    end
  end

endmodule

### hdl/spdf_checker.sv
`timescale 1ns / 1ps
`include "spring_damper_force_defines.svh"
module spdf_checker import spdf_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input logic     clk,
  input logic     rst,
  input logic     start,
  input logic     busy,
  input request_t request,
  input logic     done,
  input result_t  result
);

  localparam int LAT = LAT_BASE + FRAC_BITS;

  `SPDF_AST_IMP(a_done_has_request, done, $past(start && !busy, LAT), "result without request")

  `SPDF_AST_NXT(a_request_has_done, start && !busy, ##(LAT-1) done, "request lost")

  `SPDF_AST_IMP(a_idle_force_zero, done && !result.applied, (result.force_x == 0 && result.force_y == 0), "force without spring")

  `SPDF_AST_NXT(a_coincident, start && !busy && request.anchor_x == request.body_x && request.anchor_y == request.body_y, ##(LAT-1) (!result.applied), "coincident request applied")

endmodule

bind spring_damper_force spdf_checker #(.FRAC_BITS(FRAC_BITS)) u_spdf_checker (.*);
